FILE: hdl/block_free_list_allocator_assert.svh
// ----------------------------------------------------------------------------
// block free list allocator assertion macros
// shared property forms for the allocator checks
// ----------------------------------------------------------------------------
`ifndef BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bfla_pkg.sv
// ----------------------------------------------------------------------------
// bfla_pkg
// types, codes and sizes shared by the block free list allocator
// ----------------------------------------------------------------------------
package bfla_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int BLK_W      = 11;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int DATA_W     = 24;

    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_stat;

    localparam t_cmd CMD_ALLOC = 2'd0;
    localparam t_cmd CMD_FREE  = 2'd1;
    localparam t_cmd CMD_SET   = 2'd2;

    localparam t_stat ST_OK   = 2'd0;
    localparam t_stat ST_FULL = 2'd1;
    localparam t_stat ST_BAD  = 2'd2;

    localparam t_blk BLK_MAX = t_blk'(NUM_BLOCKS);

    // block numbers start at 1, table rows at 0
    function automatic t_addr blk_addr(input t_blk b);
        t_blk d;
        d = b - t_blk'(1);
        return d[ADDR_W-1:0];
    endfunction

endpackage

FILE: hdl/bfla_ram.sv
// ----------------------------------------------------------------------------
// bfla_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// block_free_list_allocator
// linked free list allocator over a store of numbered blocks
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// s_axis   in   block_number[10:0] link_target[21:11] cmd[1:0]
// m_axis   out  given_block[10:0] freed_count[21:11]  status[1:0]
//
// set next, bad or unknown requests, full and fresh allocate: finish in the idle state
// allocate from the free list: one next table read, then a write
// free chain of n blocks: walked one table row per cycle
// after reset a clearing pass over all 1024 rows zeroes the next table
// a result waiting in the output register holds the next result back
// ----------------------------------------------------------------------------
module block_free_list_allocator
    import bfla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // block_number, link_target
    input  logic [CMD_W-1:0]  i_s_axis_tuser,   // cmd
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // given_block, freed_count
    output logic [STAT_W-1:0] o_m_axis_tuser    // status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    t_addr      r_clr, n_clr;
    t_blk       r_cur, n_cur;
    t_blk       r_steps, n_steps;
    t_blk       r_free_head, n_free_head;
    t_blk       r_highest, n_highest;

    logic       r_fwd_hit;
    t_blk       r_fwd_data;

    t_stat      r_res_status;
    t_blk       r_res_given;
    t_blk       r_res_freed;

    logic       r_out_valid;
    t_stat      r_out_status;
    t_blk       r_out_given;
    t_blk       r_out_freed;

    logic       w_accept;
    logic       w_slot_free;
    t_cmd       w_cmd;
    t_blk       w_blk;
    t_blk       w_link;
    t_blk       w_rd;
    t_blk       w_steps_n;

    logic       w_we;
    t_addr      w_waddr;
    t_blk       w_wdata;
    t_addr      w_raddr;
    t_blk       w_ram_rdata;

    logic       w_fin;
    t_stat      w_fin_status;
    t_blk       w_fin_given;
    t_blk       w_fin_freed;
    logic       w_load_out;
    logic       w_load_res;
    t_stat      w_out_status;
    t_blk       w_out_given;
    t_blk       w_out_freed;

    bfla_ram #(
        .WIDTH (BLK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_next_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign w_cmd           = i_s_axis_tuser;
    assign w_blk           = i_s_axis_tdata[BLK_W-1:0];
    assign w_link          = i_s_axis_tdata[2*BLK_W-1:BLK_W];
    assign w_rd            = r_fwd_hit ? r_fwd_data : w_ram_rdata;
    assign w_steps_n       = r_steps + t_blk'(1);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_free_head  = r_free_head;
        n_highest    = r_highest;
        w_we         = 1'b0;
        w_waddr      = blk_addr(r_cur);
        w_wdata      = '0;
        w_raddr      = blk_addr(r_cur);
        w_fin        = 1'b0;
        w_fin_status = ST_OK;
        w_fin_given  = '0;
        w_fin_freed  = '0;
        w_load_out   = 1'b0;
        w_load_res   = 1'b0;
        w_out_status = r_res_status;
        w_out_given  = r_res_given;
        w_out_freed  = r_res_freed;

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + t_addr'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_ALLOC: begin
                            if (r_free_head != '0) begin
                                n_cur   = r_free_head;
                                w_raddr = blk_addr(r_free_head);
                                n_state = S_ALLOC;
                            end else if (r_highest < BLK_MAX) begin
                                n_highest   = r_highest + t_blk'(1);
                                w_we        = 1'b1;
                                w_waddr     = blk_addr(n_highest);
                                w_fin       = 1'b1;
                                w_fin_given = n_highest;
                            end else begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_FULL;
                            end
                        end
                        CMD_FREE: begin
                            if (w_blk > BLK_MAX) begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_BAD;
                            end else if (w_blk == '0) begin
                                w_fin = 1'b1;
                            end else begin
                                n_cur   = w_blk;
                                n_steps = '0;
                                w_raddr = blk_addr(w_blk);
                                n_state = S_WALK;
                            end
                        end
                        CMD_SET: begin
                            w_fin = 1'b1;
                            if (w_blk == '0 || w_blk > BLK_MAX || w_link > BLK_MAX) begin
                                w_fin_status = ST_BAD;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = blk_addr(w_blk);
                                w_wdata = w_link;
                            end
                        end
                        default: begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_free_head = w_rd;
                w_we        = 1'b1;
                w_waddr     = blk_addr(r_cur);
                w_fin       = 1'b1;
                w_fin_given = r_cur;
            end
            S_WALK: begin
                w_we        = 1'b1;
                w_waddr     = blk_addr(r_cur);
                w_wdata     = r_free_head;
                n_free_head = r_cur;
                n_steps     = w_steps_n;
                if (w_rd != '0 && w_steps_n < BLK_MAX) begin
                    n_cur   = w_rd;
                    w_raddr = blk_addr(w_rd);
                end else begin
                    w_fin        = 1'b1;
                    w_fin_freed  = w_steps_n;
                    w_fin_status = (w_rd != '0) ? ST_BAD : ST_OK;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            w_out_status = w_fin_status;
            w_out_given  = w_fin_given;
            w_out_freed  = w_fin_freed;
            if (w_slot_free) begin
                w_load_out = 1'b1;
                n_state    = S_IDLE;
            end else begin
                w_load_res = 1'b1;
                n_state    = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free_head <= '0;
            r_highest   <= '0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_head <= n_free_head;
            r_highest   <= n_highest;
            r_fwd_hit   <= w_we && (w_waddr == w_raddr);
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_fwd_data <= w_wdata;
        if (w_load_res) begin
            r_res_status <= w_fin_status;
            r_res_given  <= w_fin_given;
            r_res_freed  <= w_fin_freed;
        end
        if (w_load_out) begin
            r_out_status <= w_out_status;
            r_out_given  <= w_out_given;
            r_out_freed  <= w_out_freed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {(DATA_W - 2*BLK_W)'(0), r_out_freed, r_out_given};

`include "block_free_list_allocator_assert.svh"

    `BFLA_ASSERT_NOW(a_walk_bound, r_state == S_WALK, r_steps < BLK_MAX,
        "free chain walk ran past the step limit")
    `BFLA_ASSERT_NOW(a_head_range, 1'b1, r_free_head <= BLK_MAX && r_highest <= BLK_MAX,
        "free head or high mark out of range")
    `BFLA_ASSERT_NEXT(a_done_blocked, r_state == S_DONE && !w_slot_free,
        r_state == S_DONE && r_out_valid,
        "pending result left while output was busy")
    `BFLA_ASSERT_NEXT(a_clear_end, r_state == S_CLEAR && r_clr == '1,
        r_state == S_IDLE && r_clr == '0,
        "clearing pass did not end after the last row")

endmodule
